>>> rtl/jspt_pkg.sv
`timescale 1ns / 1ps
package jspt_pkg;

	// coordinate width default
	localparam int COORD_BITS_DEF = 24;

	// multiplier limb width (partial products are (LIMB_W+1) x (LIMB_W+1) signed)
	localparam int LIMB_W = 24;

	// configuration port
	localparam int LIMIT_W    = 23;
	localparam int COS_W      = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 23;

	localparam logic [CFG_IDX_W-1:0] CFG_LINE_DIST = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COS_ANGLE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EP_DIST   = 2'd3;

	localparam logic [LIMIT_W-1:0] LINE_DIST_RST = 23'd256;
	localparam logic [LIMIT_W-1:0] MIN_LEN_RST   = 23'd256;
	localparam logic [COS_W-1:0]   COS_ANGLE_RST = 17'd56756;
	localparam logic [LIMIT_W-1:0] EP_DIST_RST   = 23'd256;

	// cosine is Q1.16, so its square carries 32 fraction bits
	localparam int ANGLE_SHIFT = 32;

	// result queue depth, must exceed the pipeline latency
	localparam int OQ_DEPTH = 16;

endpackage

>>> rtl/jspt_mul.sv
`timescale 1ns / 1ps
module jspt_mul #(
	parameter int AW = 25,
	parameter int BW = 25
) (
	input  logic                    clk,
	input  logic signed [AW-1:0]    a,
	input  logic signed [BW-1:0]    b,
	output logic signed [AW+BW-1:0] p
);
	import jspt_pkg::*;

	localparam int NA  = (AW + LIMB_W - 1) / LIMB_W;
	localparam int NB  = (BW + LIMB_W - 1) / LIMB_W;
	localparam int PW  = AW + BW;
	localparam int PPW = 2 * LIMB_W + 2;

	logic signed [NA*LIMB_W-1:0] a_x;
	logic signed [NB*LIMB_W-1:0] b_x;
	logic signed [LIMB_W:0]      a_limb [NA];
	logic signed [LIMB_W:0]      b_limb [NB];
	logic signed [PPW-1:0]       pp_s1 [NA][NB];
	logic signed [PW-1:0]        row_d [NA];
	logic signed [PW-1:0]        row_s2 [NA];
	logic signed [PW-1:0]        sum_d;
	logic signed [PW-1:0]        p_s3;

	assign a_x = (NA*LIMB_W)'(a);
	assign b_x = (NB*LIMB_W)'(b);

	// lower limbs are unsigned, the top limb carries the sign
	always_comb begin
		for (int i = 0; i < NA; i++) begin
			if (i == NA - 1) begin
				a_limb[i] = {a_x[i*LIMB_W + LIMB_W - 1], a_x[i*LIMB_W +: LIMB_W]};
			end else begin
				a_limb[i] = {1'b0, a_x[i*LIMB_W +: LIMB_W]};
			end
		end
		for (int j = 0; j < NB; j++) begin
			if (j == NB - 1) begin
				b_limb[j] = {b_x[j*LIMB_W + LIMB_W - 1], b_x[j*LIMB_W +: LIMB_W]};
			end else begin
				b_limb[j] = {1'b0, b_x[j*LIMB_W +: LIMB_W]};
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				pp_s1[i][j] <= a_limb[i] * b_limb[j];
			end
		end
	end

	// sums are taken modulo 2^PW; the exact product fits PW bits
	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row_d[i] = '0;
			for (int j = 0; j < NB; j++) begin
				row_d[i] = row_d[i] + (PW'(pp_s1[i][j]) <<< (j * LIMB_W));
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NA; i++) begin
			row_s2[i] <= row_d[i];
		end
	end

	always_comb begin
		sum_d = '0;
		for (int i = 0; i < NA; i++) begin
			sum_d = sum_d + (row_s2[i] <<< (i * LIMB_W));
		end
	end

	always_ff @(posedge clk) begin
		p_s3 <= sum_d;
	end

	assign p = p_s3;

endmodule

>>> rtl/joint_segment_pair_test.sv
`timescale 1ns / 1ps
// Joint test for a pair of 3D segments (P1,Q1) and (P2,Q2).
// Input channel: in_valid/in_ready with the twelve coordinates of one pair.
// Output channel: out_valid/out_ready with is_joint, one result per pair,
// in input order.
// Configuration: cfg_we writes cfg_data into register cfg_index (line
// distance limit, minimum length, cosine bound, endpoint distance limit);
// write only while no transaction is in flight.
// Throughput: one pair per cycle while in_ready is high. The datapath is a free-running
// 12-stage pipeline built from three rounds of pipelined limb multipliers; each result
// is pushed into the output queue as its pair leaves the last stage, and out_valid
// rises once the queue holds a result.
// Stall: the pipeline never stops. A 16-entry result queue with a credit
// count takes the results; in_ready drops once 16 transactions are
// accepted but not yet delivered, and rises again as out_ready drains it.
// Reset: arst_n clears the pipeline valids, queue and credit count and
// loads the configuration registers with their defaults.
module joint_segment_pair_test #(
	parameter int COORD_BITS = jspt_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [COORD_BITS-1:0]        first_start_x,
	input  logic signed [COORD_BITS-1:0]        first_start_y,
	input  logic signed [COORD_BITS-1:0]        first_start_z,
	input  logic signed [COORD_BITS-1:0]        first_end_x,
	input  logic signed [COORD_BITS-1:0]        first_end_y,
	input  logic signed [COORD_BITS-1:0]        first_end_z,
	input  logic signed [COORD_BITS-1:0]        second_start_x,
	input  logic signed [COORD_BITS-1:0]        second_start_y,
	input  logic signed [COORD_BITS-1:0]        second_start_z,
	input  logic signed [COORD_BITS-1:0]        second_end_x,
	input  logic signed [COORD_BITS-1:0]        second_end_y,
	input  logic signed [COORD_BITS-1:0]        second_end_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                is_joint,
	input  logic                                cfg_we,
	input  logic [jspt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [jspt_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import jspt_pkg::*;

	localparam int DW    = COORD_BITS + 1;
	localparam int PW1   = 2 * DW;
	localparam int CW    = PW1 + 1;
	localparam int SW3   = PW1 + 2;
	localparam int CCW   = 2 * CW + 2;
	localparam int WCW   = DW + CW + 2;
	localparam int NNW   = 2 * SW3;
	localparam int DD2W  = 2 * SW3;
	localparam int LSQW  = 2 * (LIMIT_W + 1);
	localparam int CSQW  = 2 * (COS_W + 1);
	localparam int WC2W  = 2 * WCW;
	localparam int LCCW  = LSQW + CCW;
	localparam int CNNW  = CSQW + NNW;
	localparam int LHSW  = DD2W + ANGLE_SHIFT;
	localparam int LENW  = (SW3 > LSQW) ? SW3 : LSQW;
	localparam int CMPL  = (WC2W > LCCW) ? WC2W : LCCW;
	localparam int CMPA  = (LHSW > CNNW) ? LHSW : CNNW;
	localparam int NSTG  = 12;
	localparam int QPW   = $clog2(OQ_DEPTH);
	localparam int CNTW  = $clog2(OQ_DEPTH + 1);

	// configuration
	logic [LIMIT_W-1:0] line_distance_limit_q;
	logic [LIMIT_W-1:0] min_segment_length_q;
	logic [COS_W-1:0]   cos_min_angle_q;
	logic [LIMIT_W-1:0] endpoint_distance_limit_q;

	logic signed [LIMIT_W:0] line_sx;
	logic signed [LIMIT_W:0] len_sx;
	logic signed [LIMIT_W:0] ep_sx;
	logic signed [COS_W:0]   cos_sx;
	logic signed [LSQW-1:0]  lsq;
	logic signed [LSQW-1:0]  msq;
	logic signed [LSQW-1:0]  esq;
	logic signed [CSQW-1:0]  csq;

	// handshake and queue
	logic                  in_acc;
	logic                  out_acc;
	logic [NSTG-1:0]       vld_q;
	logic [CNTW-1:0]       cnt_q;
	logic [QPW:0]          wr_ptr_q;
	logic [QPW:0]          rd_ptr_q;
	logic                  oq_mem_q [OQ_DEPTH];
	logic                  push;
	logic                  push_data;

	// datapath
	logic signed [COORD_BITS-1:0] p1 [3];
	logic signed [COORD_BITS-1:0] q1 [3];
	logic signed [COORD_BITS-1:0] p2 [3];
	logic signed [COORD_BITS-1:0] q2 [3];

	logic signed [DW-1:0]   d1_s1 [3];
	logic signed [DW-1:0]   d2_s1 [3];
	logic signed [DW-1:0]   w_s1 [3];
	logic signed [DW-1:0]   ev_s1 [4][3];
	logic signed [DW-1:0]   w_s2 [3];
	logic signed [DW-1:0]   w_s3 [3];
	logic signed [DW-1:0]   w_s4 [3];
	logic signed [DW-1:0]   w_s5 [3];

	logic signed [PW1-1:0]  cpos_s4 [3];
	logic signed [PW1-1:0]  cneg_s4 [3];
	logic signed [PW1-1:0]  n1p_s4 [3];
	logic signed [PW1-1:0]  n2p_s4 [3];
	logic signed [PW1-1:0]  ddp_s4 [3];
	logic signed [PW1-1:0]  epp_s4 [4][3];
	logic signed [SW3-1:0]  ep_sum [4];
	logic [3:0]             ep_hit;

	logic signed [CW-1:0]   c_s5 [3];
	logic signed [SW3-1:0]  n1_s5;
	logic signed [SW3-1:0]  n2_s5;
	logic signed [SW3-1:0]  dd_s5;
	logic signed [SW3-1:0]  dd_s6;
	logic signed [SW3-1:0]  dd_s7;
	logic signed [SW3-1:0]  dd_s8;
	logic signed [SW3-1:0]  dd_s9;
	logic                   ep_ok_s5;
	logic                   len_ok_s6;

	logic signed [2*CW-1:0] ccp_s8 [3];
	logic signed [DW+CW-1:0] wcp_s8 [3];
	logic signed [NNW-1:0]  nn_s8;
	logic signed [CCW-1:0]  cc_s9;
	logic signed [WCW-1:0]  wc_s9;
	logic signed [NNW-1:0]  nn_s9;
	logic                   nz_s10;

	logic signed [WC2W-1:0] wc2_s12;
	logic signed [LCCW-1:0] lcc_s12;
	logic signed [CNNW-1:0] cnn_s12;
	logic signed [DD2W-1:0] dd2_s12;

	logic [6:0]             ep_dly_q;
	logic [5:0]             len_dly_q;
	logic [1:0]             nz_dly_q;
	logic                   line_ok;
	logic                   angle_ok;

	// ---------------------------------------------------------------
	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_distance_limit_q     <= LINE_DIST_RST;
			min_segment_length_q      <= MIN_LEN_RST;
			cos_min_angle_q           <= COS_ANGLE_RST;
			endpoint_distance_limit_q <= EP_DIST_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LINE_DIST: line_distance_limit_q     <= cfg_data[LIMIT_W-1:0];
				CFG_MIN_LEN:   min_segment_length_q      <= cfg_data[LIMIT_W-1:0];
				CFG_COS_ANGLE: cos_min_angle_q           <= cfg_data[COS_W-1:0];
				CFG_EP_DIST:   endpoint_distance_limit_q <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign line_sx = {1'b0, line_distance_limit_q};
	assign len_sx  = {1'b0, min_segment_length_q};
	assign ep_sx   = {1'b0, endpoint_distance_limit_q};
	assign cos_sx  = {1'b0, cos_min_angle_q};

	// squared limits come from pipelined multipliers and trail a write
	jspt_mul #(.AW(LIMIT_W + 1), .BW(LIMIT_W + 1)) u_lsq (
		.clk, .a(line_sx), .b(line_sx), .p(lsq)
	);
	jspt_mul #(.AW(LIMIT_W + 1), .BW(LIMIT_W + 1)) u_msq (
		.clk, .a(len_sx), .b(len_sx), .p(msq)
	);
	jspt_mul #(.AW(LIMIT_W + 1), .BW(LIMIT_W + 1)) u_esq (
		.clk, .a(ep_sx), .b(ep_sx), .p(esq)
	);
	jspt_mul #(.AW(COS_W + 1), .BW(COS_W + 1)) u_csq (
		.clk, .a(cos_sx), .b(cos_sx), .p(csq)
	);

	// ---------------------------------------------------------------
	// handshake, valid tracking and result queue
	assign in_ready  = (cnt_q < CNTW'(OQ_DEPTH));
	assign in_acc    = in_valid & in_ready;
	assign out_valid = (wr_ptr_q != rd_ptr_q);
	assign out_acc   = out_valid & out_ready;
	assign is_joint  = oq_mem_q[rd_ptr_q[QPW-1:0]];
	assign push      = vld_q[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			cnt_q    <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			vld_q <= {vld_q[NSTG-2:0], in_acc};
			case ({in_acc, out_acc})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (out_acc) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			oq_mem_q[wr_ptr_q[QPW-1:0]] <= push_data;
		end
	end

	// ---------------------------------------------------------------
	// stage 1: direction, offset and endpoint difference vectors
	assign p1[0] = first_start_x;
	assign p1[1] = first_start_y;
	assign p1[2] = first_start_z;
	assign q1[0] = first_end_x;
	assign q1[1] = first_end_y;
	assign q1[2] = first_end_z;
	assign p2[0] = second_start_x;
	assign p2[1] = second_start_y;
	assign p2[2] = second_start_z;
	assign q2[0] = second_end_x;
	assign q2[1] = second_end_y;
	assign q2[2] = second_end_z;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			d1_s1[k]    <= DW'(q1[k]) - DW'(p1[k]);
			d2_s1[k]    <= DW'(q2[k]) - DW'(p2[k]);
			w_s1[k]     <= DW'(p2[k]) - DW'(p1[k]);
			ev_s1[0][k] <= DW'(p2[k]) - DW'(p1[k]);
			ev_s1[1][k] <= DW'(q2[k]) - DW'(p1[k]);
			ev_s1[2][k] <= DW'(q1[k]) - DW'(p2[k]);
			ev_s1[3][k] <= DW'(q2[k]) - DW'(q1[k]);
			w_s2[k]     <= w_s1[k];
			w_s3[k]     <= w_s2[k];
			w_s4[k]     <= w_s3[k];
			w_s5[k]     <= w_s4[k];
		end
	end

	// stages 2-4: first round of products
	for (genvar k = 0; k < 3; k++) begin : g_ra
		jspt_mul #(.AW(DW), .BW(DW)) u_cpos (
			.clk, .a(d1_s1[(k + 1) % 3]), .b(d2_s1[(k + 2) % 3]), .p(cpos_s4[k])
		);
		jspt_mul #(.AW(DW), .BW(DW)) u_cneg (
			.clk, .a(d1_s1[(k + 2) % 3]), .b(d2_s1[(k + 1) % 3]), .p(cneg_s4[k])
		);
		jspt_mul #(.AW(DW), .BW(DW)) u_n1 (
			.clk, .a(d1_s1[k]), .b(d1_s1[k]), .p(n1p_s4[k])
		);
		jspt_mul #(.AW(DW), .BW(DW)) u_n2 (
			.clk, .a(d2_s1[k]), .b(d2_s1[k]), .p(n2p_s4[k])
		);
		jspt_mul #(.AW(DW), .BW(DW)) u_dd (
			.clk, .a(d1_s1[k]), .b(d2_s1[k]), .p(ddp_s4[k])
		);
		for (genvar m = 0; m < 4; m++) begin : g_ep
			jspt_mul #(.AW(DW), .BW(DW)) u_ep (
				.clk, .a(ev_s1[m][k]), .b(ev_s1[m][k]), .p(epp_s4[m][k])
			);
		end
	end

	// stage 5: cross product, norms, dot product, endpoint proximity
	always_comb begin
		for (int m = 0; m < 4; m++) begin
			ep_sum[m] = SW3'(epp_s4[m][0]) + SW3'(epp_s4[m][1]) + SW3'(epp_s4[m][2]);
			ep_hit[m] = (LENW'(ep_sum[m]) < LENW'(esq));
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			c_s5[k] <= CW'(cpos_s4[k]) - CW'(cneg_s4[k]);
		end
		n1_s5    <= SW3'(n1p_s4[0]) + SW3'(n1p_s4[1]) + SW3'(n1p_s4[2]);
		n2_s5    <= SW3'(n2p_s4[0]) + SW3'(n2p_s4[1]) + SW3'(n2p_s4[2]);
		dd_s5    <= SW3'(ddp_s4[0]) + SW3'(ddp_s4[1]) + SW3'(ddp_s4[2]);
		ep_ok_s5 <= |ep_hit;
		dd_s6    <= dd_s5;
		dd_s7    <= dd_s6;
		dd_s8    <= dd_s7;
		dd_s9    <= dd_s8;
		len_ok_s6 <= (LENW'(n1_s5) > LENW'(msq)) && (LENW'(n2_s5) > LENW'(msq));
	end

	// stages 6-8: second round of products
	for (genvar k = 0; k < 3; k++) begin : g_rb
		jspt_mul #(.AW(CW), .BW(CW)) u_cc (
			.clk, .a(c_s5[k]), .b(c_s5[k]), .p(ccp_s8[k])
		);
		jspt_mul #(.AW(DW), .BW(CW)) u_wc (
			.clk, .a(w_s5[k]), .b(c_s5[k]), .p(wcp_s8[k])
		);
	end

	jspt_mul #(.AW(SW3), .BW(SW3)) u_nn (
		.clk, .a(n1_s5), .b(n2_s5), .p(nn_s8)
	);

	// stage 9: |c|^2 and w.c
	always_ff @(posedge clk) begin
		cc_s9  <= CCW'(ccp_s8[0]) + CCW'(ccp_s8[1]) + CCW'(ccp_s8[2]);
		wc_s9  <= WCW'(wcp_s8[0]) + WCW'(wcp_s8[1]) + WCW'(wcp_s8[2]);
		nn_s9  <= nn_s8;
		nz_s10 <= (cc_s9 != '0);
	end

	// stages 10-12: third round of products
	jspt_mul #(.AW(WCW), .BW(WCW)) u_wc2 (
		.clk, .a(wc_s9), .b(wc_s9), .p(wc2_s12)
	);
	jspt_mul #(.AW(LSQW), .BW(CCW)) u_lcc (
		.clk, .a(lsq), .b(cc_s9), .p(lcc_s12)
	);
	jspt_mul #(.AW(CSQW), .BW(NNW)) u_cnn (
		.clk, .a(csq), .b(nn_s9), .p(cnn_s12)
	);
	jspt_mul #(.AW(SW3), .BW(SW3)) u_dd2 (
		.clk, .a(dd_s9), .b(dd_s9), .p(dd2_s12)
	);

	// carry the early test flags along to stage 12
	always_ff @(posedge clk) begin
		ep_dly_q  <= {ep_dly_q[5:0], ep_ok_s5};
		len_dly_q <= {len_dly_q[4:0], len_ok_s6};
		nz_dly_q  <= {nz_dly_q[0], nz_s10};
	end

	// final compare feeds the result queue
	assign line_ok   = (CMPL'(wc2_s12) < CMPL'(lcc_s12));
	assign angle_ok  = ((CMPA'(dd2_s12) <<< ANGLE_SHIFT) <= CMPA'(cnn_s12));
	assign push_data = ep_dly_q[6] & len_dly_q[5] & nz_dly_q[1] & line_ok & angle_ok;

`ifndef SYNTHESIS
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(OQ_DEPTH))
		else $error("outstanding transaction count exceeds queue depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> ((QPW + 1)'(wr_ptr_q - rd_ptr_q) < (QPW + 1)'(OQ_DEPTH)))
		else $error("result pushed into a full queue");

	a_credit_match: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) == $countones(vld_q) + 32'((QPW + 1)'(wr_ptr_q - rd_ptr_q)))
		else $error("credit count disagrees with pipeline and queue contents");
`endif

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
module tb;
	import jspt_pkg::*;

	localparam int CRD_W        = COORD_BITS_DEF;
	localparam int CRD_MAX      = 8388607;
	localparam int CRD_MIN      = -8388608;
	localparam int BASE_REACH   = CRD_MAX - 70000;
	localparam int NDIR         = 24;
	localparam int NPHASE       = 6;
	localparam int PHASE_ITEMS  = 205;
	localparam int RAND_PICK    = -1;
	localparam int SETTLE       = 20;
	localparam int LIMIT_CYCLES = 400000;

	typedef logic signed [CRD_W-1:0] coord_t;
	typedef logic signed [255:0] acc_t;
	typedef enum logic [1:0] {WANT_MODEL, WANT_NO, WANT_YES} verdict_src_t;

	// coordinate order: P1 xyz, Q1 xyz, P2 xyz, Q2 xyz
	localparam int DIR_COORD [NDIR][12] = '{
		'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, 1000, 0, 0, 0, 0, 0, 0, 1000, 0},
		'{0, 0, 0, 1000, 0, 0, 0, 10, 0, 1000, 10, 0},
		'{0, 0, 0, 1000, 0, 0, 0, 0, 255, 0, 1000, 255},
		'{0, 0, 0, 1000, 0, 0, 0, 0, 256, 0, 1000, 256},
		'{0, 0, 0, 256, 0, 0, 0, 0, 0, 0, 1000, 0},
		'{0, 0, 0, 257, 0, 0, 0, 0, 0, 0, 1000, 0},
		'{0, 0, 0, 1000, 0, 0, 0, 0, 0, 0, 256, 0},
		'{0, 0, 0, 1000, 0, 0, 0, 0, 0, 1000, 1000, 0},
		'{0, 0, 0, 1000, 0, 0, 0, 0, 0, 1000, 100, 0},
		'{0, 0, 0, 1000, 0, 0, 0, 0, 0, 866, 500, 0},
		'{0, 0, 0, 1000, 0, 0, 0, 1000, 0, 0, 0, 0},
		'{0, 0, 0, 1000, 0, 0, 1000, 0, 0, 1000, 1000, 0},
		'{1000, 0, 0, 0, 0, 0, 0, 1000, 0, 0, 0, 0},
		'{0, 0, 0, 1000, 0, 0, 500, -500, 0, 500, 500, 0},
		'{0, 0, 0, 1000, 0, 0, -255, 0, 0, -255, 1000, 0},
		'{0, 0, 0, 1000, 0, 0, -256, 0, 0, -256, 1000, 0},
		'{CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX,
		  CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX},
		'{CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN,
		  CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN},
		'{CRD_MIN, CRD_MIN, CRD_MIN, CRD_MAX, CRD_MAX, CRD_MAX,
		  CRD_MAX, CRD_MIN, CRD_MAX, CRD_MIN, CRD_MAX, CRD_MIN},
		'{CRD_MAX, CRD_MIN, 0, CRD_MIN, CRD_MAX, 0,
		  CRD_MIN, CRD_MIN, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MIN},
		'{5, 5, 5, 5, 5, 5, 0, 0, 0, 100, 0, 0},
		'{-1, -1, -1, 1000, -1, -1, -1, -1, -1, -1, 1000, -1},
		'{0, 0, 0, 1000, 0, 0, 1000, 0, 5, 0, 0, 5}
	};

	localparam verdict_src_t DIR_WANT [NDIR] = '{
		WANT_NO, WANT_YES, WANT_NO, WANT_MODEL, WANT_MODEL, WANT_MODEL,
		WANT_MODEL, WANT_MODEL, WANT_MODEL, WANT_MODEL, WANT_MODEL, WANT_MODEL,
		WANT_MODEL, WANT_MODEL, WANT_MODEL, WANT_MODEL, WANT_MODEL, WANT_NO,
		WANT_NO, WANT_MODEL, WANT_MODEL, WANT_NO, WANT_MODEL, WANT_NO
	};

	// line limit, min length, cosine, endpoint limit; phase 0 keeps reset values
	localparam int PHASE_REGS [NPHASE][4] = '{
		'{256, 256, 56756, 256},
		'{CRD_MAX, 0, 65536, CRD_MAX},
		'{0, 0, 0, 0},
		'{300, 64, CRD_MAX, 400},
		'{RAND_PICK, RAND_PICK, RAND_PICK, RAND_PICK},
		'{1000, 500, 46341, 1000}
	};

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	coord_t pin [12];
	logic out_valid;
	logic out_ready;
	logic is_joint;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic [LIMIT_W-1:0] line_lim;
	logic [LIMIT_W-1:0] len_min;
	logic [COS_W-1:0] cos_lim;
	logic [LIMIT_W-1:0] ep_lim;

	verdict_src_t cur_src;
	bit verdicts [$];
	bit calm;
	int errors;
	int accepted;
	int joints;
	int cycles;

	joint_segment_pair_test #(.COORD_BITS(CRD_W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.first_start_x(pin[0]),
		.first_start_y(pin[1]),
		.first_start_z(pin[2]),
		.first_end_x(pin[3]),
		.first_end_y(pin[4]),
		.first_end_z(pin[5]),
		.second_start_x(pin[6]),
		.second_start_y(pin[7]),
		.second_start_z(pin[8]),
		.second_end_x(pin[9]),
		.second_end_y(pin[10]),
		.second_end_z(pin[11]),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.is_joint(is_joint),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// squared distance between points a and b (0 = P1, 1 = Q1, 2 = P2, 3 = Q2)
	function automatic acc_t sq_gap(input coord_t pr [12], input int a, input int b);
		acc_t s;
		acc_t t;
		s = '0;
		for (int k = 0; k < 3; k++) begin
			t = acc_t'(pr[3 * b + k]) - acc_t'(pr[3 * a + k]);
			s = s + t * t;
		end
		return s;
	endfunction

	function automatic bit joint_verdict(input coord_t pr [12]);
		acc_t d1 [3];
		acc_t d2 [3];
		acc_t w [3];
		acc_t c [3];
		acc_t cc;
		acc_t wc;
		acc_t n1;
		acc_t n2;
		acc_t dd;
		acc_t lim;
		bit ok;
		for (int k = 0; k < 3; k++) begin
			d1[k] = acc_t'(pr[3 + k]) - acc_t'(pr[k]);
			d2[k] = acc_t'(pr[9 + k]) - acc_t'(pr[6 + k]);
			w[k]  = acc_t'(pr[6 + k]) - acc_t'(pr[k]);
		end
		c[0] = d1[1] * d2[2] - d1[2] * d2[1];
		c[1] = d1[2] * d2[0] - d1[0] * d2[2];
		c[2] = d1[0] * d2[1] - d1[1] * d2[0];
		cc = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
		wc = w[0] * c[0] + w[1] * c[1] + w[2] * c[2];
		// parallel or degenerate lines never match
		ok = (cc != 0);

		lim = acc_t'(line_lim);
		ok = ok && (wc * wc < lim * lim * cc);

		lim = acc_t'(len_min);
		lim = lim * lim;
		n1 = sq_gap(pr, 0, 1);
		n2 = sq_gap(pr, 2, 3);
		ok = ok && (n1 > lim) && (n2 > lim);

		dd = d1[0] * d2[0] + d1[1] * d2[1] + d1[2] * d2[2];
		lim = acc_t'(cos_lim);
		ok = ok && (((dd * dd) <<< ANGLE_SHIFT) <= lim * lim * n1 * n2);

		lim = acc_t'(ep_lim);
		lim = lim * lim;
		ok = ok && (sq_gap(pr, 0, 2) < lim || sq_gap(pr, 0, 3) < lim ||
			sq_gap(pr, 2, 1) < lim || sq_gap(pr, 1, 3) < lim);
		return ok;
	endfunction

	function automatic bit take_break();
		return !calm && ($urandom_range(0, 99) < 11);
	endfunction

	task automatic send_pair(input coord_t pr [12], input verdict_src_t src);
		@(negedge clk);
		while (take_break()) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		pin = pr;
		cur_src = src;
		do @(posedge clk); while (!in_ready);
	endtask

	// drop valid and hold until every pair in flight has come back
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (verdicts.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = CFG_DATA_W'(val);
		case (idx)
			CFG_LINE_DIST: line_lim = cfg_data[LIMIT_W-1:0];
			CFG_MIN_LEN:   len_min = cfg_data[LIMIT_W-1:0];
			CFG_COS_ANGLE: cos_lim = cfg_data[COS_W-1:0];
			CFG_EP_DIST:   ep_lim = cfg_data[LIMIT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready = !take_break();
		end
	end

	always @(posedge clk) begin
		bit want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				case (cur_src)
					WANT_YES: verdicts.insert(verdicts.size(), 1'b1);
					WANT_NO:  verdicts.insert(verdicts.size(), 1'b0);
					default:  verdicts.insert(verdicts.size(), joint_verdict(pin));
				endcase
				accepted++;
			end
			if (out_valid && out_ready) begin
				if (is_joint === 1'b1)
					joints++;
				if (verdicts.size() == 0) begin
					$error("is_joint: transaction with nothing pending, expected none, got %0b",
						is_joint);
					errors++;
				end else begin
					want = verdicts.pop_front();
					if (is_joint !== want) begin
						$error("is_joint: expected %0b, got %0b", want, is_joint);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("joint_segment_pair_test verification failed");
			$finish;
		end
	end

	initial begin
		coord_t pr [12];
		int pt [12];
		int base [3];
		int da [3];
		int db [3];
		int jit [3];
		int span;
		int jr;
		int r;
		int m;
		int val;
		int hold;

		arst_n = 1'b0;
		in_valid = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cur_src = WANT_MODEL;
		calm = 1'b0;
		for (int k = 0; k < 12; k++)
			pin[k] = '0;
		line_lim = LINE_DIST_RST;
		len_min = MIN_LEN_RST;
		cos_lim = COS_ANGLE_RST;
		ep_lim = EP_DIST_RST;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < NDIR; i++) begin
			for (int k = 0; k < 12; k++)
				pr[k] = coord_t'(DIR_COORD[i][k]);
			send_pair(pr, DIR_WANT[i]);
		end
		drain();

		for (int ph = 0; ph < NPHASE; ph++) begin
			if (ph > 0) begin
				for (int g = 0; g < 4; g++) begin
					val = PHASE_REGS[ph][g];
					if (val == RAND_PICK)
						val = (g == 2) ? int'($urandom_range(0, 65536))
							: int'($urandom_range(0, 2000));
					write_reg(CFG_IDX_W'(g), val);
				end
			end
			// one phase runs with both sides streaming at full rate
			calm = (ph == 1);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				r = $urandom_range(0, 99);
				if (r < 12) begin
					for (int k = 0; k < 12; k++)
						pt[k] = int'($urandom());
				end else if (r < 20) begin
					for (int k = 0; k < 12; k++) begin
						case ($urandom_range(0, 4))
							0: pt[k] = CRD_MIN;
							1: pt[k] = CRD_MAX;
							2: pt[k] = 0;
							3: pt[k] = -1;
							default: pt[k] = int'($urandom());
						endcase
					end
				end else begin
					// two segments sharing a nearby endpoint; parallel when r < 30
					span = 1 << $urandom_range(3, 15);
					jr = ($urandom_range(0, 3) == 0) ? 1200 : 200;
					m = int'($urandom_range(0, 4)) - 2;
					for (int k = 0; k < 3; k++) begin
						base[k] = int'($urandom_range(0, 2 * BASE_REACH)) - BASE_REACH;
						da[k] = int'($urandom_range(0, 2 * span)) - span;
						db[k] = int'($urandom_range(0, 2 * span)) - span;
						jit[k] = int'($urandom_range(0, 2 * jr)) - jr;
						pt[k] = base[k];
						pt[3 + k] = base[k] + da[k];
						pt[6 + k] = base[k] + jit[k];
						pt[9 + k] = (r < 30) ? pt[6 + k] + da[k] * m : pt[6 + k] + db[k];
					end
					if ($urandom_range(0, 1) == 1) begin
						for (int k = 0; k < 3; k++) begin
							hold = pt[k];
							pt[k] = pt[3 + k];
							pt[3 + k] = hold;
						end
					end
					if ($urandom_range(0, 1) == 1) begin
						for (int k = 0; k < 3; k++) begin
							hold = pt[6 + k];
							pt[6 + k] = pt[9 + k];
							pt[9 + k] = hold;
						end
					end
				end
				for (int k = 0; k < 12; k++)
					pr[k] = coord_t'(pt[k]);
				send_pair(pr, WANT_MODEL);
			end
			drain();
		end
		calm = 1'b0;

		repeat (SETTLE) @(posedge clk);
		$display("Checked %0d segment pairs under %0d register settings, %0d reported as joints.",
			accepted, NPHASE, joints);
		if (errors == 0)
			$display("joint_segment_pair_test verification clean");
		else
			$display("joint_segment_pair_test verification failed");
		$finish;
	end

endmodule
